/* hdl/sepq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted event priority queue package
// Shared types, request and status codes for the sorted event chain.
// ----------------------------------------------------------------------------
package sepq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 64;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [31:0] event_time;
    logic        event_kind;
    logic [3:0]  queue_index;
  } req_t;

  typedef struct packed {
    logic [31:0] head_time;
    logic        head_kind;
    logic [3:0]  head_queue;
    logic [6:0]  entry_total;
    logic        is_empty;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic        kind;
    logic [3:0]  qidx;
  } slot_t;

  typedef struct packed {
    logic  ins;
    logic  rem;
    slot_t ent;
  } cell_ctl_t;

endpackage

/* hdl/sepq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted event chain cell
// Holds one event and either keeps it, takes the new event, takes the
// left neighbor's event on insert, or takes the right neighbor's on remove.
// ----------------------------------------------------------------------------
module sepq_cell import sepq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,
  input  logic      left_keep,
  input  slot_t     left_slot,
  input  slot_t     right_slot,
  output logic      keep,
  output slot_t     slot,
  output slot_t     slot_nxt
);

  slot_t slot_r;

  assign keep = occupied && (slot_r.stamp <= ctl.ent.stamp);

  always_comb begin
    slot_nxt = slot_r;
    if (ctl.ins) begin
      if (!keep) begin
        slot_nxt = left_keep ? ctl.ent : left_slot;
      end
    end else if (ctl.rem) begin
      slot_nxt = right_slot;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot = slot_r;

endmodule

/* hdl/sorted_event_priority_queue.sv */
// A transaction's result is registered and presented in the cycle after acceptance.
// One transaction per cycle unless stalled; all cells compare and shift at once.
// A new transaction is taken while the previous result is being taken.
// Reset clears the entry count and the result valid flag; slot contents are
// not reset and are never read before being written.
// ----------------------------------------------------------------------------
// Sorted event priority queue
// A chain of cells kept in ascending time order, with insert and remove.
// ----------------------------------------------------------------------------
module sorted_event_priority_queue import sepq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  rsp_t          out_data_r;
  rsp_t          rsp_nxt;
  logic          accept;
  logic          is_full;
  logic          no_entries;
  cell_ctl_t     ctl;

  logic  keep     [QUEUE_DEPTH];
  slot_t slots    [QUEUE_DEPTH];
  slot_t slots_nx [QUEUE_DEPTH];

  assign in_stall   = out_valid_r && out_stall;
  assign accept     = in_valid && !in_stall;
  assign is_full    = (count_r == CW'(QUEUE_DEPTH));
  assign no_entries = (count_r == '0);

  always_comb begin
    ctl.ent.stamp = in_data.event_time;
    ctl.ent.kind  = in_data.event_kind;
    ctl.ent.qidx  = in_data.queue_index;
    ctl.ins = accept && (in_data.req_type == REQ_INSERT) && !is_full;
    ctl.rem = accept && (in_data.req_type == REQ_REMOVE) && !no_entries;
  end

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic  left_keep;
      slot_t left_slot;
      slot_t right_slot;

      if (gi == 0) begin : g_first
        assign left_keep = 1'b1;
        assign left_slot = ctl.ent;
      end else begin : g_mid
        assign left_keep = keep[gi-1];
        assign left_slot = slots[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign right_slot = slots[gi];
      end else begin : g_inner
        assign right_slot = slots[gi+1];
      end

      sepq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (CW'(gi) < count_r),
        .left_keep  (left_keep),
        .left_slot  (left_slot),
        .right_slot (right_slot),
        .keep       (keep[gi]),
        .slot       (slots[gi]),
        .slot_nxt   (slots_nx[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    rsp_nxt.status = STATUS_OK;
    if (in_data.req_type == REQ_INSERT && is_full) begin
      rsp_nxt.status = STATUS_FULL;
    end else if (in_data.req_type == REQ_REMOVE && no_entries) begin
      rsp_nxt.status = STATUS_EMPTY;
    end
    rsp_nxt.entry_total = 7'(count_nxt);
    rsp_nxt.is_empty    = (count_nxt == '0);
    if (count_nxt == '0) begin
      rsp_nxt.head_time  = '0;
      rsp_nxt.head_kind  = 1'b0;
      rsp_nxt.head_queue = '0;
    end else begin
      rsp_nxt.head_time  = slots_nx[0].stamp;
      rsp_nxt.head_kind  = slots_nx[0].kind;
      rsp_nxt.head_queue = slots_nx[0].qidx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
